@@ hdl/bolsu_pkg.sv @@
// ----------------------------------------------------------------------------
// bolsu_pkg
// Shared types, constants and commutation tables for the BLDC open-loop
// startup sequencer.
// ----------------------------------------------------------------------------
package bolsu_pkg;

  // Width of the ramp period state (commutation timer width)
  localparam int unsigned TIMER_BITS    = 16;
  // Compare width wide enough for both the ramp and the 16-bit registers
  localparam int unsigned RAMP_CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Register reset values
  localparam logic        REVERSE_RST    = 1'b0;
  localparam logic [15:0] START_PER_RST  = 16'd10000;
  localparam logic [15:0] MIN_PER_RST    = 16'd1000;
  localparam logic [15:0] PER_STEP_RST   = 16'd10;
  localparam logic [15:0] START_CMP_RST  = 16'd100;
  localparam logic [7:0]  CYC_CLOSE_RST  = 8'd10;

  // Sector bounds
  localparam logic [2:0] SECTOR_IDLE  = 3'd0;
  localparam logic [2:0] SECTOR_FIRST = 3'd1;
  localparam logic [2:0] SECTOR_LAST  = 3'd6;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_REVERSE   = 3'd0,
    CFG_START_PER = 3'd1,
    CFG_MIN_PER   = 3'd2,
    CFG_PER_STEP  = 3'd3,
    CFG_START_CMP = 3'd4,
    CFG_CYC_CLOSE = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_A    = 2'd0,
    PH_B    = 2'd1,
    PH_C    = 2'd2,
    PH_NONE = 2'd3
  } phase_e;

  typedef struct packed {
    logic        reverse;
    logic [15:0] start_period;
    logic [15:0] min_period;
    logic [15:0] period_step;
    logic [15:0] startup_compare;
    logic [7:0]  cycles_to_close;
  } cfg_t;

  typedef struct packed {
    logic [2:0]            sector;
    logic [TIMER_BITS-1:0] ramp;
    logic [7:0]            count;
    logic                  closed;
  } state_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [1:0]  high_phase;
    logic [1:0]  low_phase;
    logic        period_load;
    logic [15:0] period_value;
    logic        compare_load;
    logic [15:0] duty_compare;
    logic        closed_loop;
    logic        handover;
  } result_t;

  // High side driven with PWM per sector
  function automatic phase_e high_phase_f(logic [2:0] sec);
    phase_e ph;
    case (sec)
      3'd1, 3'd6: ph = PH_A;
      3'd2, 3'd3: ph = PH_B;
      3'd4, 3'd5: ph = PH_C;
      default:    ph = PH_NONE;
    endcase
    return ph;
  endfunction

  // Low side switched on per sector
  function automatic phase_e low_phase_f(logic [2:0] sec);
    phase_e ph;
    case (sec)
      3'd1, 3'd2: ph = PH_C;
      3'd3, 3'd4: ph = PH_A;
      3'd5, 3'd6: ph = PH_B;
      default:    ph = PH_NONE;
    endcase
    return ph;
  endfunction

endpackage

@@ hdl/bolsu_ifs.sv @@
// ----------------------------------------------------------------------------
// bolsu channel interfaces
// Tick request, result and configuration write channels.
// ----------------------------------------------------------------------------

// Tick request channel
interface bolsu_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// Result channel
interface bolsu_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  sector;
  logic [1:0]  high_phase;
  logic [1:0]  low_phase;
  logic        period_load;
  logic [15:0] period_value;
  logic        compare_load;
  logic [15:0] duty_compare;
  logic        closed_loop;
  logic        handover;

  modport source (
    output valid, output sector, output high_phase, output low_phase,
    output period_load, output period_value, output compare_load,
    output duty_compare, output closed_loop, output handover,
    input ready
  );
  modport sink (
    input valid, input sector, input high_phase, input low_phase,
    input period_load, input period_value, input compare_load,
    input duty_compare, input closed_loop, input handover,
    output ready
  );
endinterface

// Configuration write channel
interface bolsu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/bolsu_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bolsu_cfg_regs
// Configuration register file; flags start_period writes for the ramp load.
// ----------------------------------------------------------------------------
module bolsu_cfg_regs
  import bolsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  bolsu_cfg_if.sink        cfg_i,
  output cfg_t             cfg_o,
  output logic             start_wr_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // Register decode
  always_comb begin
    cfg_d      = cfg_q;
    start_wr_o = 1'b0;
    if (wr_en) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_REVERSE:   cfg_d.reverse = cfg_i.data[0];
        CFG_START_PER: begin
          cfg_d.start_period = cfg_i.data;
          start_wr_o         = 1'b1;
        end
        CFG_MIN_PER:   cfg_d.min_period      = cfg_i.data;
        CFG_PER_STEP:  cfg_d.period_step     = cfg_i.data;
        CFG_START_CMP: cfg_d.startup_compare = cfg_i.data;
        CFG_CYC_CLOSE: cfg_d.cycles_to_close = cfg_i.data[7:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse         <= REVERSE_RST;
      cfg_q.start_period    <= START_PER_RST;
      cfg_q.min_period      <= MIN_PER_RST;
      cfg_q.period_step     <= PER_STEP_RST;
      cfg_q.startup_compare <= START_CMP_RST;
      cfg_q.cycles_to_close <= CYC_CLOSE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/bolsu_step.sv @@
// ----------------------------------------------------------------------------
// bolsu_step
// One commutation step: next sector, phase table, loads, ramp and close check.
// ----------------------------------------------------------------------------
module bolsu_step
  import bolsu_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  logic    tick_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [2:0]               sec_n;
  logic                     pload;
  logic                     cload;
  logic                     cnt_inc;
  logic [7:0]               count_n;
  logic                     match;
  logic [RAMP_CMP_BITS-1:0] ramp_ext;
  logic [RAMP_CMP_BITS-1:0] min_ext;
  logic [RAMP_CMP_BITS-1:0] step_ext;
  logic [TIMER_BITS-1:0]    ramp_n;
  logic                     active;

  assign active = tick_i && !state_i.closed;

  // Sector advance with wrap; idle or invalid codes restart the sequence
  always_comb begin
    if (cfg_i.reverse) begin
      if (state_i.sector <= SECTOR_FIRST || state_i.sector > SECTOR_LAST) begin
        sec_n = SECTOR_LAST;
      end else begin
        sec_n = state_i.sector - 3'd1;
      end
    end else begin
      if (state_i.sector >= SECTOR_LAST) begin
        sec_n = SECTOR_FIRST;
      end else begin
        sec_n = state_i.sector + 3'd1;
      end
    end
  end

  // Per-sector loads and electrical cycle counting
  always_comb begin
    pload   = 1'b0;
    cload   = 1'b0;
    cnt_inc = 1'b0;
    case (sec_n)
      3'd1: pload = cfg_i.reverse;
      3'd2: begin
        pload = 1'b1;
        cload = !cfg_i.reverse;
      end
      3'd3: pload = 1'b1;
      3'd4: begin
        pload   = 1'b1;
        cnt_inc = cfg_i.reverse;
      end
      3'd5: begin
        pload   = 1'b1;
        cload   = cfg_i.reverse;
        cnt_inc = !cfg_i.reverse;
      end
      default: pload = !cfg_i.reverse;
    endcase
  end

  assign count_n = cnt_inc ? state_i.count + 8'd1 : state_i.count;
  assign match   = (count_n == cfg_i.cycles_to_close);

  // Period ramp, saturating at zero
  assign ramp_ext = RAMP_CMP_BITS'(state_i.ramp);
  assign min_ext  = RAMP_CMP_BITS'(cfg_i.min_period);
  assign step_ext = RAMP_CMP_BITS'(cfg_i.period_step);

  always_comb begin
    ramp_n = state_i.ramp;
    if (ramp_ext > min_ext) begin
      if (ramp_ext > step_ext) begin
        ramp_n = TIMER_BITS'(ramp_ext - step_ext);
      end else begin
        ramp_n = '0;
      end
    end
  end

  // Next state and result
  always_comb begin
    state_o               = state_i;
    result_o.sector       = state_i.sector;
    result_o.high_phase   = PH_NONE;
    result_o.low_phase    = PH_NONE;
    result_o.period_load  = 1'b0;
    result_o.period_value = ramp_ext[15:0];
    result_o.compare_load = 1'b0;
    result_o.duty_compare = '0;
    result_o.closed_loop  = state_i.closed;
    result_o.handover     = 1'b0;
    if (active) begin
      state_o.sector        = sec_n;
      state_o.ramp          = ramp_n;
      state_o.count         = count_n;
      state_o.closed        = match;
      result_o.sector       = sec_n;
      result_o.high_phase   = high_phase_f(sec_n);
      result_o.low_phase    = low_phase_f(sec_n);
      result_o.period_load  = pload;
      result_o.compare_load = cload;
      result_o.duty_compare = cload ? cfg_i.startup_compare : 16'd0;
      result_o.closed_loop  = match;
      result_o.handover     = match;
    end
  end

endmodule

@@ hdl/bldc_open_loop_startup_core.sv @@
// ----------------------------------------------------------------------------
// bldc_open_loop_startup_core
// Six-step BLDC open-loop startup sequencer: steps the commutation sector per
// timer tick, ramps the period down and hands over to closed loop.
//
//   channel  dir  payload                                   accept
//   cfg_i    in   index[2:0], data[15:0]                    valid & ready
//   req_i    in   tick                                      valid & ready
//   res_o    out  sector, phases, loads, period, duty, flags valid & ready
//
// One request per cycle sustained while results are taken; a result passes
// through the input register, then the step logic into the result register.
// The step logic reads and writes the sequencer state in the same cycle, so
// back-to-back requests chain through it without bubbles.
// Reset returns the sequencer state to idle with the ramp at the start period default and loads the register defaults.
// A stalled result holds in its register; the input stage fills behind it and
// frees up in the cycle the result is taken.
// ----------------------------------------------------------------------------
module bldc_open_loop_startup_core
  import bolsu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  bolsu_cfg_if.sink        cfg_i,
  bolsu_tick_if.sink       req_i,
  bolsu_result_if.source   res_o
);

  localparam logic [TIMER_BITS-1:0] RAMP_RST = TIMER_BITS'(START_PER_RST);

  cfg_t    cfg;
  logic    start_wr;
  state_t  state_q, state_d, step_state;
  result_t step_res;
  result_t res_q;
  logic    res_valid_q;
  logic    in_valid_q;
  logic    in_tick_q;
  logic    res_free;
  logic    in_adv;

  // Configuration registers
  bolsu_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .cfg_o      (cfg),
    .start_wr_o (start_wr)
  );

  // Step logic
  bolsu_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .tick_i   (in_tick_q),
    .state_o  (step_state),
    .result_o (step_res)
  );

  // Handshake
  assign res_free    = !res_valid_q || res_o.ready;
  assign in_adv      = in_valid_q && res_free;
  assign req_i.ready = !in_valid_q || res_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_tick_q <= req_i.tick;
    end
  end

  // Sequencer state; a start_period write reloads the ramp before startup
  always_comb begin
    state_d = state_q;
    if (in_adv) begin
      state_d = step_state;
    end else if (start_wr && state_q.sector == SECTOR_IDLE && !state_q.closed) begin
      state_d.ramp = TIMER_BITS'(cfg_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.sector <= SECTOR_IDLE;
      state_q.ramp   <= RAMP_RST;
      state_q.count  <= '0;
      state_q.closed <= 1'b0;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      res_q <= step_res;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.sector       = res_q.sector;
  assign res_o.high_phase   = res_q.high_phase;
  assign res_o.low_phase    = res_q.low_phase;
  assign res_o.period_load  = res_q.period_load;
  assign res_o.period_value = res_q.period_value;
  assign res_o.compare_load = res_q.compare_load;
  assign res_o.duty_compare = res_q.duty_compare;
  assign res_o.closed_loop  = res_q.closed_loop;
  assign res_o.handover     = res_q.handover;

  // Closed loop is sticky until reset
  a_closed_sticky: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $past(state_q.closed) |-> state_q.closed
  ) else $error("closed-loop flag dropped");

  // A handover result always reports closed loop
  a_handover_closed: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      res_valid_q && res_q.handover |-> res_q.closed_loop
  ) else $error("handover without closed loop");

  // A compare load only happens on a sector that also reloads the period
  a_cload_pload: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      res_valid_q && res_q.compare_load |-> res_q.period_load
  ) else $error("compare load without period load");

  // Empty input stage never stalls a request
  a_in_ready: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !in_valid_q |-> req_i.ready
  ) else $error("input stage empty but not ready");

endmodule

@@ sim/bolsu_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// bolsu_tb_pkg
// Scoreboard for the BLDC open-loop startup sequencer: keeps its own copy of
// the registers and the commutation state, predicts one result per accepted
// tick request and checks the results in order, field by field.
// ----------------------------------------------------------------------------
package bolsu_tb_pkg;
  import bolsu_pkg::*;

  class commutation_scoreboard;
    // Register copy
    logic                  reverse;
    logic [15:0]           start_period;
    logic [15:0]           min_period;
    logic [15:0]           period_step;
    logic [15:0]           startup_compare;
    logic [7:0]            cycles_to_close;
    // Sequencer state
    logic [2:0]            sector;
    logic [TIMER_BITS-1:0] ramp;
    logic [7:0]            elec_cycles;
    logic                  closed;
    bit                    cycles_wrapped;
    // Results still owed by the block, oldest first
    result_t               expected_steps[$];
    int unsigned           errors;

    function new();
      reverse         = REVERSE_RST;
      start_period    = START_PER_RST;
      min_period      = MIN_PER_RST;
      period_step     = PER_STEP_RST;
      startup_compare = START_CMP_RST;
      cycles_to_close = CYC_CLOSE_RST;
      sector          = SECTOR_IDLE;
      ramp            = TIMER_BITS'(START_PER_RST);
      elec_cycles     = '0;
      closed          = 1'b0;
      cycles_wrapped  = 1'b0;
      errors          = 0;
    endfunction

    // Register write; start_period only reaches the ramp before the first step
    function void note_config(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_REVERSE:   reverse = data[0];
        CFG_START_PER: begin
          start_period = data;
          if (sector == SECTOR_IDLE && !closed) ramp = TIMER_BITS'(data);
        end
        CFG_MIN_PER:   min_period = data;
        CFG_PER_STEP:  period_step = data;
        CFG_START_CMP: startup_compare = data;
        CFG_CYC_CLOSE: cycles_to_close = data[7:0];
        default: ;
      endcase
    endfunction

    function phase_e high_side(logic [2:0] s);
      case (s)
        3'd1, 3'd6: return PH_A;
        3'd2, 3'd3: return PH_B;
        3'd4, 3'd5: return PH_C;
        default:    return PH_NONE;
      endcase
    endfunction

    function phase_e low_side(logic [2:0] s);
      case (s)
        3'd1, 3'd2: return PH_C;
        3'd3, 3'd4: return PH_A;
        3'd5, 3'd6: return PH_B;
        default:    return PH_NONE;
      endcase
    endfunction

    // Predict the result of one accepted tick request and advance the state
    function void note_request(logic tick);
      result_t    exp;
      logic [2:0] next_sector;
      exp              = '0;
      exp.high_phase   = PH_NONE;
      exp.low_phase    = PH_NONE;
      exp.period_value = 16'(ramp);
      if (!tick || closed) begin
        // ignored tick: held sector, nothing driven
        exp.sector      = sector;
        exp.closed_loop = closed;
      end else begin
        if (reverse)
          next_sector = (sector <= SECTOR_FIRST || sector > SECTOR_LAST) ?
                        SECTOR_LAST : sector - 3'd1;
        else
          next_sector = (sector >= SECTOR_LAST) ? SECTOR_FIRST : sector + 3'd1;
        sector         = next_sector;
        exp.sector     = next_sector;
        exp.high_phase = high_side(next_sector);
        exp.low_phase  = low_side(next_sector);
        case (next_sector)
          SECTOR_FIRST: exp.period_load = reverse;
          SECTOR_LAST:  exp.period_load = !reverse;
          default:      exp.period_load = 1'b1;
        endcase
        exp.compare_load = (next_sector == 3'd2 && !reverse) ||
                           (next_sector == 3'd5 && reverse);
        exp.duty_compare = exp.compare_load ? startup_compare : 16'd0;
        // one electrical cycle per pass through the counting sector
        if ((next_sector == 3'd5 && !reverse) || (next_sector == 3'd4 && reverse)) begin
          elec_cycles = elec_cycles + 8'd1;
          if (elec_cycles == 8'd0) cycles_wrapped = 1'b1;
        end
        // ramp down while above the floor, clamp at zero
        if (ramp > min_period) begin
          if (ramp > period_step) ramp = TIMER_BITS'(ramp - period_step);
          else ramp = '0;
        end
        if (elec_cycles == cycles_to_close) begin
          closed       = 1'b1;
          exp.handover = 1'b1;
        end
        exp.closed_loop = closed;
      end
      expected_steps.push_back(exp);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH: %s", msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] exp);
      if (got !== exp)
        report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, exp));
    endtask

    // Check one accepted result against the oldest prediction
    task check_result(result_t got);
      result_t exp;
      if (expected_steps.size() == 0) begin
        report_mismatch("result with no pending request");
        return;
      end
      exp = expected_steps.pop_front();
      compare_field("sector", got.sector, exp.sector);
      compare_field("high_phase", got.high_phase, exp.high_phase);
      compare_field("low_phase", got.low_phase, exp.low_phase);
      compare_field("period_load", got.period_load, exp.period_load);
      compare_field("period_value", got.period_value, exp.period_value);
      compare_field("compare_load", got.compare_load, exp.compare_load);
      compare_field("duty_compare", got.duty_compare, exp.duty_compare);
      compare_field("closed_loop", got.closed_loop, exp.closed_loop);
      compare_field("handover", got.handover, exp.handover);
    endtask

    function int unsigned pending();
      return expected_steps.size();
    endfunction
  endclass

endpackage

@@ sim/bldc_open_loop_startup_core_tb.sv @@
// ----------------------------------------------------------------------------
// bldc_open_loop_startup_core_tb
// Drives tick requests and register writes into the startup sequencer and
// checks every result against the scoreboard's prediction. A short directed
// run covers the sector wraps in both directions, reverse start from idle,
// ignored ticks and start_period loading; random phases follow with varied
// settings and idling, a long result hold-off, the electrical cycle counter
// wrapping, ramp underflow, and finally the handover into closed loop.
// ----------------------------------------------------------------------------
module bldc_open_loop_startup_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bolsu_pkg::*;
  import bolsu_tb_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Register indexes with no register behind them
  localparam logic [2:0]  CFG_SPARE_LO    = 3'd6;
  localparam logic [2:0]  CFG_SPARE_HI    = 3'd7;

  logic clk_i;
  logic rst_ni;

  bolsu_cfg_if    cfg_if ();
  bolsu_tick_if   tick_if ();
  bolsu_result_if res_if ();

  bldc_open_loop_startup_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (tick_if),
    .res_o  (res_if)
  );

  commutation_scoreboard sb = new();

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_off_req    = 0;
  int unsigned idle_cycles     = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result receiver: random stalls, plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Handshake monitor
  always @(posedge clk_i) begin
    result_t got;
    bit      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.note_config(cfg_if.index, cfg_if.data);
        moved = 1'b1;
      end
      if (tick_if.valid && tick_if.ready) begin
        sb.note_request(tick_if.tick);
        moved = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        got.sector       = res_if.sector;
        got.high_phase   = res_if.high_phase;
        got.low_phase    = res_if.low_phase;
        got.period_load  = res_if.period_load;
        got.period_value = res_if.period_value;
        got.compare_load = res_if.compare_load;
        got.duty_compare = res_if.duty_compare;
        got.closed_loop  = res_if.closed_loop;
        got.handover     = res_if.handover;
        sb.check_result(got);
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // Watchdog: too long without any handshake
  initial begin
    do @(posedge clk_i); while (idle_cycles < STALL_LIMIT);
    $display("bldc_open_loop_startup_core test failed");
    $finish;
  end

  function automatic logic random_tick();
    return $urandom_range(0, 31) != 0;
  endfunction

  function automatic logic [15:0] pick_wide();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Close count that the cycle counter cannot reach within horizon electrical cycles
  function automatic logic [7:0] close_target(logic [7:0] want, int unsigned horizon);
    logic [7:0] gap;
    gap = want - sb.elec_cycles;
    return (gap > horizon) ? want : sb.elec_cycles - 8'd1;
  endfunction

  // One tick request, with random idling ahead of it
  task automatic send_tick(logic tick);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.tick  <= tick;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  // Stop offering requests and wait for every owed result
  task automatic settle();
    tick_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic load_random_config(int unsigned horizon);
    logic [15:0] pad;
    logic [7:0]  target;
    pad    = 16'($urandom);
    target = close_target(8'($urandom), horizon);
    write_reg(CFG_REVERSE, 16'($urandom));
    write_reg(CFG_START_PER, pick_wide());
    write_reg(CFG_MIN_PER, 16'($urandom_range(0, 3000)));
    write_reg(CFG_PER_STEP, 16'($urandom_range(0, 64)));
    write_reg(CFG_START_CMP, pick_wide());
    write_reg(CFG_CYC_CLOSE, {pad[15:8], target});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_ticks(int unsigned n_items, int unsigned idle_pct,
                           int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (n_items) send_tick(random_tick());
    settle();
  endtask

  task automatic random_phase(int unsigned n_items, int unsigned idle_pct,
                              int unsigned stall_pct);
    load_random_config(n_items / 6 + 2);
    run_ticks(n_items, idle_pct, stall_pct);
  endtask

  // Stimulus
  initial begin
    int unsigned n;
    rst_ni        <= 1'b0;
    tick_if.valid <= 1'b0;
    tick_if.tick  <= 1'b0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= CFG_REVERSE;
    cfg_if.data   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Not started: empty ticks, start_period reloads the ramp
    send_tick(1'b0);
    settle();
    write_reg(CFG_START_PER, 16'd1);
    cfg_if.valid <= 1'b0;
    send_tick(1'b0);
    settle();
    write_reg(CFG_START_PER, 16'hFFFF);
    write_reg(CFG_REVERSE, 16'h0001);
    write_reg(CFG_SPARE_LO, 16'($urandom));
    write_reg(CFG_SPARE_HI, 16'($urandom));
    cfg_if.valid <= 1'b0;
    send_tick(1'b0);
    // Reverse from idle enters the last sector, then wraps past the first
    repeat (7) send_tick(1'b1);
    settle();

    // Direction change mid-run, extreme compare, ramp frozen
    write_reg(CFG_REVERSE, 16'hFFFE);
    write_reg(CFG_START_CMP, 16'hFFFF);
    write_reg(CFG_PER_STEP, 16'h0000);
    write_reg(CFG_MIN_PER, 16'hFFFF);
    write_reg(CFG_CYC_CLOSE, 16'hFF00);
    cfg_if.valid <= 1'b0;
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    repeat (5) send_tick(1'b1);
    settle();

    // Random phases over the idling patterns
    random_phase(250, 0, 0);
    random_phase(250, 69, 0);
    random_phase(250, 0, 69);
    random_phase(250, 23, 23);

    // Result side holds off while requests keep coming
    load_random_config(27);
    hold_off_req = HOLD_OFF_CYCLES;
    run_ticks(150, 0, 0);

    // Register extremes
    write_reg(CFG_REVERSE, 16'hFFFF);
    write_reg(CFG_START_PER, 16'h0000);
    write_reg(CFG_MIN_PER, 16'h0000);
    write_reg(CFG_PER_STEP, 16'd1);
    write_reg(CFG_START_CMP, 16'h0000);
    write_reg(CFG_CYC_CLOSE, {8'h00, close_target(8'hFF, 27)});
    cfg_if.valid <= 1'b0;
    run_ticks(150, 23, 23);

    // Run on until the electrical cycle counter wraps
    load_random_config(124);
    sender_idle_pct = 23;
    recv_stall_pct  = 23;
    n = 0;
    while (!sb.cycles_wrapped && n < 700) begin
      send_tick(random_tick());
      n++;
    end
    repeat (30) send_tick(random_tick());
    settle();

    // Step larger than the period: ramp clamps at zero
    write_reg(CFG_MIN_PER, 16'h0000);
    write_reg(CFG_PER_STEP, 16'hFFFF);
    cfg_if.valid <= 1'b0;
    run_ticks(60, 23, 23);

    // Close count equal to the current count: the next step outside the counting sector hands over
    write_reg(CFG_CYC_CLOSE, {8'h00, sb.elec_cycles});
    cfg_if.valid <= 1'b0;
    run_ticks(40, 23, 23);
    // Closed loop: start_period must not touch the ramp any more
    write_reg(CFG_START_PER, 16'h1234);
    cfg_if.valid <= 1'b0;
    run_ticks(10, 0, 0);

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("bldc_open_loop_startup_core test passed");
    else
      $display("bldc_open_loop_startup_core test failed");
    $finish;
  end

endmodule
